>>> hdl/fn_pkg.sv
package fn_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAG_W      = DATA_WIDTH - 1;
  localparam int CNT_W      = $clog2(MAG_W);

  typedef enum logic [1:0] {
    OP_EUCLID,
    OP_NUMER,
    OP_DENOM
  } fn_op_e;

  typedef struct packed {
    logic   load;
    logic   div_start;
    fn_op_e div_sel;
    logic   div_step;
    logic   euc_update;
    logic   store_qn;
    logic   out_load;
  } fn_cmd_t;

  typedef struct packed {
    logic zero;
    logic y_zero;
    logic div_last;
  } fn_sts_t;

endpackage

>>> hdl/fn_if.sv
interface fn_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fn_pkg::DATA_WIDTH-1:0] numerator;
  logic signed [fn_pkg::DATA_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface fn_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fn_pkg::DATA_WIDTH-1:0] reduced_numerator;
  logic        [fn_pkg::MAG_W-1:0]      reduced_denominator;

  modport source (output valid, output reduced_numerator, output reduced_denominator,
                  input ready);
  modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                  output ready);
endinterface

>>> hdl/fn_dp.sv
module fn_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fn_pkg::fn_cmd_t               cmd_i,
  output fn_pkg::fn_sts_t               sts_o,
  input  logic [fn_pkg::DATA_WIDTH-1:0] numerator_i,
  input  logic [fn_pkg::DATA_WIDTH-1:0] denominator_i,
  output logic [fn_pkg::DATA_WIDTH-1:0] reduced_numerator_o,
  output logic [fn_pkg::MAG_W-1:0]      reduced_denominator_o
);

  localparam int DW = fn_pkg::DATA_WIDTH;
  localparam int MW = fn_pkg::MAG_W;
  localparam int CW = fn_pkg::CNT_W;

  logic [MW-1:0] x_q, y_q, nmag_q, dmag_q, qn_q;
  logic [MW-1:0] rem_q, quo_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          sign_q, zero_q;
  logic [DW-1:0] rn_q;
  logic [MW-1:0] rd_q;

  logic [MW-1:0] nmag, dmag;
  logic [DW-1:0] nneg_full, dneg_full;
  logic [MW:0]   part, diff;
  logic          ge;
  logic [MW-1:0] rem_step, quo_step;
  logic [MW-1:0] dividend, divisor;
  logic [DW-1:0] qn_ext;

  // Magnitude of a two's complement input; the most negative value saturates.
  always_comb begin
    nneg_full = ~numerator_i + DW'(1);
    dneg_full = ~denominator_i + DW'(1);
    if (!numerator_i[DW-1]) begin
      nmag = numerator_i[MW-1:0];
    end else if (numerator_i[MW-1:0] == '0) begin
      nmag = '1;
    end else begin
      nmag = nneg_full[MW-1:0];
    end
    if (!denominator_i[DW-1]) begin
      dmag = denominator_i[MW-1:0];
    end else if (denominator_i[MW-1:0] == '0) begin
      dmag = '1;
    end else begin
      dmag = dneg_full[MW-1:0];
    end
  end

  // One restoring division step per cycle.
  assign part     = {rem_q, quo_q[MW-1]};
  assign diff     = part - {1'b0, div_q};
  assign ge       = ~diff[MW];
  assign rem_step = ge ? diff[MW-1:0] : part[MW-1:0];
  assign quo_step = {quo_q[MW-2:0], ge};

  always_comb begin
    case (cmd_i.div_sel)
      fn_pkg::OP_EUCLID: begin
        dividend = x_q;
        divisor  = y_q;
      end
      fn_pkg::OP_NUMER: begin
        dividend = nmag_q;
        divisor  = x_q;
      end
      fn_pkg::OP_DENOM: begin
        dividend = dmag_q;
        divisor  = x_q;
      end
      default: begin
        dividend = x_q;
        divisor  = y_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  assign qn_ext = {1'b0, qn_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nmag_q <= nmag;
      dmag_q <= dmag;
      x_q    <= nmag;
      y_q    <= dmag;
      sign_q <= numerator_i[DW-1] ^ denominator_i[DW-1];
      zero_q <= (nmag == '0) || (dmag == '0);
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= dividend;
      div_q <= divisor;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_step;
      quo_q <= quo_step;
    end
    if (cmd_i.div_step && cmd_i.euc_update) begin
      x_q <= y_q;
      y_q <= rem_step;
    end
    if (cmd_i.div_step && cmd_i.store_qn) begin
      qn_q <= quo_step;
    end
    if (cmd_i.out_load) begin
      if (zero_q) begin
        rn_q <= '0;
        rd_q <= MW'(1);
      end else begin
        rn_q <= sign_q ? (~qn_ext + DW'(1)) : qn_ext;
        rd_q <= quo_q;
      end
    end
  end

  assign sts_o.zero     = zero_q;
  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.div_last = (cnt_q == CW'(MW - 1));

  assign reduced_numerator_o   = rn_q;
  assign reduced_denominator_o = rd_q;

endmodule

>>> hdl/fn_ctrl.sv
module fn_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  fn_pkg::fn_sts_t sts_i,
  output fn_pkg::fn_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EUC_CHK   = 3'd1;
  localparam logic [2:0] S_EUC_DIV   = 3'd2;
  localparam logic [2:0] S_NUM_DIV   = 3'd3;
  localparam logic [2:0] S_DEN_START = 3'd4;
  localparam logic [2:0] S_DEN_DIV   = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d          = state_q;
    cmd_o.load       = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.div_sel    = fn_pkg::OP_EUCLID;
    cmd_o.div_step   = 1'b0;
    cmd_o.euc_update = 1'b0;
    cmd_o.store_qn   = 1'b0;
    cmd_o.out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EUC_CHK;
        end
      end
      S_EUC_CHK: begin
        if (sts_i.zero) begin
          state_d = S_DONE;
        end else if (sts_i.y_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = fn_pkg::OP_NUMER;
          state_d         = S_NUM_DIV;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = fn_pkg::OP_EUCLID;
          state_d         = S_EUC_DIV;
        end
      end
      S_EUC_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.euc_update = 1'b1;
          state_d          = S_EUC_CHK;
        end
      end
      S_NUM_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.store_qn = 1'b1;
          state_d        = S_DEN_START;
        end
      end
      S_DEN_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = fn_pkg::OP_DENOM;
        state_d         = S_DEN_DIV;
      end
      S_DEN_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("Pending result was dropped while the receiver stalled.");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EUC_CHK)
    else $error("Accepted transaction did not start the reduction.");

  a_euclid_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EUC_DIV && sts_i.div_last |=> state_q == S_EUC_CHK)
    else $error("Euclid remainder step did not return to the check.");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.div_start, cmd_o.div_step, cmd_o.out_load}))
    else $error("Conflicting datapath commands were issued.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> $past(state_q) != S_IDLE)
    else $error("Result was loaded without a completed reduction.");

endmodule

>>> hdl/fraction_normalizer.sv
// Reduces a signed fraction to standard form: the denominator is positive, the sign is
// carried by the numerator, and both are divided by their greatest common factor.
// A zero numerator or denominator gives 0/1; the most negative input saturates first.
// The input channel takes one transaction (numerator, denominator) at a time and the
// output channel returns one transaction (reduced_numerator, reduced_denominator) for it.
// All divisions run on one shared restoring divider that resolves one quotient bit
// per cycle, after a start step that loads its operands.
// The Euclid remainder steps find the greatest common factor, then the numerator and
// then the denominator are divided by it; a zero operand skips all divisions and goes
// straight to the result. A new transaction is accepted only once the previous one
// has been written to the output register, so reductions never overlap.
// The result sits in an output register; while the receiver stalls, a new transaction
// is still accepted and reduced, and only its final write waits for the register to
// free up. Reset is asynchronous and active low; it clears the controller and the
// output valid, and no arithmetic state needs clearing.
module fraction_normalizer (
  input  logic     clk_i,
  input  logic     rst_ni,
  fn_in_if.sink    in_i,
  fn_out_if.source out_o
);

  fn_pkg::fn_cmd_t cmd;
  fn_pkg::fn_sts_t sts;

  fn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fn_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .numerator_i           (in_i.numerator),
    .denominator_i         (in_i.denominator),
    .reduced_numerator_o   (out_o.reduced_numerator),
    .reduced_denominator_o (out_o.reduced_denominator)
  );

endmodule
